// File: hw/rtl/bcu_pkg.sv
// ============================================================================
// bcu_pkg: shared types and constants for the bus CPU control unit
// Request and result layouts, operation and opcode codes, status codes.
// ============================================================================
package bcu_pkg;

    localparam int MEM_BYTES   = 2048;
    localparam int IO_BYTES    = 32;
    localparam int MEM_AW      = $clog2(MEM_BYTES);
    localparam int IO_AW       = $clog2(IO_BYTES);
    localparam int ADDR_W      = 11;
    localparam int BYTE_W      = 8;
    localparam int OPC_W       = 5;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // operation codes on the request channel
    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_EXEC = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    // status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_EOP     = 2'd1;
    localparam logic [1:0] STAT_ILLEGAL = 2'd2;
    localparam logic [1:0] STAT_HALTED  = 2'd3;

    // instruction opcodes
    localparam logic [OPC_W-1:0] OPC_WM   = 5'd1;
    localparam logic [OPC_W-1:0] OPC_RM   = 5'd2;
    localparam logic [OPC_W-1:0] OPC_BR   = 5'd3;
    localparam logic [OPC_W-1:0] OPC_RIO  = 5'd4;
    localparam logic [OPC_W-1:0] OPC_WIO  = 5'd5;
    localparam logic [OPC_W-1:0] OPC_WB   = 5'd6;
    localparam logic [OPC_W-1:0] OPC_WIB  = 5'd7;
    localparam logic [OPC_W-1:0] OPC_WIB2 = 5'd8;
    localparam logic [OPC_W-1:0] OPC_EOP  = 5'd31;

    typedef enum logic [1:0] {
        KIND_LOAD,
        KIND_EXEC,
        KIND_READ,
        KIND_NOP
    } kind_t;

    typedef struct packed {
        logic [1:0]        operation;
        logic [ADDR_W-1:0] address;
        logic [BYTE_W-1:0] data;
    } in_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] fetch_pc;
        logic [OPC_W-1:0]  opcode;
        logic [ADDR_W-1:0] operand_field;
        logic [ADDR_W-1:0] address_bus;
        logic [BYTE_W-1:0] data_bus;
        logic [BYTE_W-1:0] buffer_register;
        logic [BYTE_W-1:0] io_buffer_register;
        logic              io_or_memory;
        logic              read_write;
        logic              output_enable;
    } out_t;

    // classified request held in the queue
    typedef struct packed {
        kind_t             kind;
        logic [ADDR_W-1:0] address;
        logic [BYTE_W-1:0] data;
    } req_t;

endpackage

// File: hw/rtl/bcu_ram.sv
// ============================================================================
// bcu_ram: generic single-port RAM
// One read or write per cycle, registered read data.
// ============================================================================
module bcu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/bcu_front.sv
// ============================================================================
// bcu_front: request intake
// Accepts requests, classifies the operation and queues them for execution.
// ============================================================================
module bcu_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  bcu_pkg::in_t  cmd,
    output logic          q_valid,
    input  logic          q_pop,
    output bcu_pkg::req_t q_head
);
    import bcu_pkg::*;

    req_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    req_t              req_new;
    logic              push;
    logic              pop;

    always_comb
    begin
        req_new.address = cmd.address;
        req_new.data    = cmd.data;
        case (cmd.operation)
            OP_LOAD: req_new.kind = KIND_LOAD;
            OP_EXEC: req_new.kind = KIND_EXEC;
            OP_READ: req_new.kind = KIND_READ;
            default: req_new.kind = KIND_NOP;
        endcase
    end

    assign cmd_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push      = cmd_valid && cmd_ready;
    assign q_valid   = (count_reg != '0);
    assign pop       = q_pop && q_valid;
    assign q_head    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= req_new;
        end
    end

endmodule

// File: hw/rtl/bcu_back.sv
// ============================================================================
// bcu_back: execution engine
// Runs queued requests against main memory and the I/O store, holds the CPU
// registers and the result register.
// ============================================================================
module bcu_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    output logic          q_pop,
    input  bcu_pkg::req_t q_head,
    output logic          res_valid,
    input  logic          res_ready,
    output bcu_pkg::out_t res
);
    import bcu_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_FETCH_HI,
        ST_FETCH_LO,
        ST_RM
    } state_t;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] pc_reg, pc_next;
    logic [BYTE_W-1:0] mbr_reg, mbr_next;
    logic [BYTE_W-1:0] iobr_reg, iobr_next;
    logic              halted_reg, halted_next;
    logic [BYTE_W-1:0] hi_reg, hi_next;
    logic [OPC_W-1:0]  opc_reg, opc_next;
    logic [ADDR_W-1:0] opnd_reg, opnd_next;
    logic [ADDR_W-1:0] fpc_reg, fpc_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic              out_valid_reg, out_valid_next;
    out_t              out_reg, out_next;
    logic [BYTE_W-1:0] io_reg [IO_BYTES];

    logic              ram_en;
    logic              ram_we;
    logic [MEM_AW-1:0] ram_addr;
    logic [BYTE_W-1:0] ram_wdata;
    logic [BYTE_W-1:0] ram_rdata;

    logic              io_we;
    logic [IO_AW-1:0]  io_idx;
    logic              out_free;
    logic              fin;
    out_t              res_d;
    logic [OPC_W-1:0]  opc_w;
    logic [ADDR_W-1:0] opnd_w;
    logic [ADDR_W-1:0] pc_inc1;

    bcu_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MEM_BYTES)
    ) u_mem (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign out_free = !out_valid_reg || res_ready;
    assign opc_w    = hi_reg[BYTE_W-1:BYTE_W-OPC_W];
    assign opnd_w   = {hi_reg[ADDR_W-BYTE_W-1:0], ram_rdata};
    assign pc_inc1  = pc_reg + ADDR_W'(1);
    assign io_idx   = opnd_w[IO_AW-1:0];

    always_comb
    begin
        state_next  = state_reg;
        pc_next     = pc_reg;
        mbr_next    = mbr_reg;
        iobr_next   = iobr_reg;
        halted_next = halted_reg;
        hi_next     = hi_reg;
        opc_next    = opc_reg;
        opnd_next   = opnd_reg;
        fpc_next    = fpc_reg;
        addr_next   = addr_reg;
        q_pop       = 1'b0;
        ram_en      = 1'b0;
        ram_we      = 1'b0;
        ram_addr    = pc_reg[MEM_AW-1:0];
        ram_wdata   = mbr_reg;
        io_we       = 1'b0;
        fin         = 1'b0;
        res_d       = '0;
        res_d.fetch_pc = pc_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop = 1'b1;
                    case (q_head.kind)
                        KIND_LOAD:
                        begin
                            ram_en    = 1'b1;
                            ram_we    = 1'b1;
                            ram_addr  = q_head.address[MEM_AW-1:0];
                            ram_wdata = q_head.data;
                            fin       = 1'b1;
                            res_d.address_bus   = q_head.address;
                            res_d.data_bus      = q_head.data;
                            res_d.io_or_memory  = 1'b1;
                            res_d.read_write    = 1'b1;
                            res_d.output_enable = 1'b1;
                        end
                        KIND_READ:
                        begin
                            ram_en     = 1'b1;
                            ram_addr   = q_head.address[MEM_AW-1:0];
                            addr_next  = q_head.address;
                            state_next = ST_READ;
                        end
                        KIND_EXEC:
                        begin
                            if (halted_reg)
                            begin
                                fin          = 1'b1;
                                res_d.status = STAT_HALTED;
                            end
                            else
                            begin
                                ram_en     = 1'b1;
                                fpc_next   = pc_reg;
                                state_next = ST_FETCH_HI;
                            end
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                fin        = 1'b1;
                state_next = ST_IDLE;
                res_d.address_bus   = addr_reg;
                res_d.data_bus      = ram_rdata;
                res_d.io_or_memory  = 1'b1;
                res_d.output_enable = 1'b1;
            end
            ST_FETCH_HI:
            begin
                hi_next    = ram_rdata;
                ram_en     = 1'b1;
                ram_addr   = pc_inc1[MEM_AW-1:0];
                state_next = ST_FETCH_LO;
            end
            ST_FETCH_LO:
            begin
                fin        = 1'b1;
                state_next = ST_IDLE;
                pc_next    = pc_reg + ADDR_W'(2);
                res_d.fetch_pc      = fpc_reg;
                res_d.opcode        = opc_w;
                res_d.operand_field = opnd_w;
                res_d.address_bus   = pc_inc1;
                res_d.data_bus      = ram_rdata;
                res_d.io_or_memory  = 1'b1;
                res_d.output_enable = 1'b1;
                case (opc_w)
                    OPC_WM:
                    begin
                        ram_en    = 1'b1;
                        ram_we    = 1'b1;
                        ram_addr  = opnd_w[MEM_AW-1:0];
                        ram_wdata = mbr_reg;
                        res_d.address_bus = opnd_w;
                        res_d.data_bus    = mbr_reg;
                        res_d.read_write  = 1'b1;
                    end
                    OPC_RM:
                    begin
                        // finish once the operand byte comes back
                        fin        = 1'b0;
                        ram_en     = 1'b1;
                        ram_addr   = opnd_w[MEM_AW-1:0];
                        opc_next   = opc_w;
                        opnd_next  = opnd_w;
                        state_next = ST_RM;
                    end
                    OPC_BR:
                    begin
                        pc_next = opnd_w;
                        res_d.output_enable = 1'b0;
                    end
                    OPC_RIO:
                    begin
                        iobr_next = io_reg[io_idx];
                        res_d.address_bus  = {{(ADDR_W-IO_AW){1'b0}}, io_idx};
                        res_d.data_bus     = io_reg[io_idx];
                        res_d.io_or_memory = 1'b0;
                    end
                    OPC_WIO:
                    begin
                        io_we = 1'b1;
                        res_d.address_bus  = {{(ADDR_W-IO_AW){1'b0}}, io_idx};
                        res_d.data_bus     = iobr_reg;
                        res_d.io_or_memory = 1'b0;
                        res_d.read_write   = 1'b1;
                    end
                    OPC_WB:
                    begin
                        mbr_next = opnd_w[BYTE_W-1:0];
                        res_d.output_enable = 1'b0;
                    end
                    OPC_WIB, OPC_WIB2:
                    begin
                        iobr_next = opnd_w[BYTE_W-1:0];
                        res_d.output_enable = 1'b0;
                    end
                    OPC_EOP:
                    begin
                        halted_next  = 1'b1;
                        res_d.status = STAT_EOP;
                    end
                    default:
                    begin
                        halted_next  = 1'b1;
                        res_d.status = STAT_ILLEGAL;
                    end
                endcase
            end
            ST_RM:
            begin
                fin        = 1'b1;
                state_next = ST_IDLE;
                mbr_next   = ram_rdata;
                res_d.fetch_pc      = fpc_reg;
                res_d.opcode        = opc_reg;
                res_d.operand_field = opnd_reg;
                res_d.address_bus   = opnd_reg;
                res_d.data_bus      = ram_rdata;
                res_d.io_or_memory  = 1'b1;
                res_d.output_enable = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        res_d.buffer_register    = mbr_next;
        res_d.io_buffer_register = iobr_next;

        out_valid_next = out_valid_reg && !res_ready;
        out_next       = out_reg;
        if (fin)
        begin
            out_valid_next = 1'b1;
            out_next       = res_d;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            mbr_reg       <= '0;
            iobr_reg      <= '0;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < IO_BYTES; i++)
            begin
                io_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            mbr_reg       <= mbr_next;
            iobr_reg      <= iobr_next;
            halted_reg    <= halted_next;
            out_valid_reg <= out_valid_next;
            if (io_we)
            begin
                io_reg[io_idx] <= iobr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg   <= hi_next;
        opc_reg  <= opc_next;
        opnd_reg <= opnd_next;
        fpc_reg  <= fpc_next;
        addr_reg <= addr_next;
        out_reg  <= out_next;
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

`ifndef ASSERT_OFF
    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == ST_IDLE))
        else $error("queue popped while an instruction is in flight");

    a_fin_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        fin |-> (!out_valid_reg || res_ready))
        else $error("result produced over an unconsumed result");

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halt flag cleared");

    a_fetch_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FETCH_HI) |=> (state_reg == ST_FETCH_LO))
        else $error("second fetch did not follow the first");
`endif

endmodule

// File: hw/rtl/bus_cpu_control_unit_core.sv
// ============================================================================
// bus_cpu_control_unit_core: accumulator CPU with main memory and I/O store
// Loads, reads back and executes one instruction per request, reporting bus
// and control-line values for each.
// ============================================================================
// Channel | Handshake           | Payload           | Role
// cmd     | cmd_valid/cmd_ready | bcu_pkg::in_t     | operation requests in
// res     | res_valid/res_ready | bcu_pkg::out_t    | one result per request
//
// Load, no-op and halted execute finish in the intake state. Read adds a result
// state. Execute runs two fetch reads, then decode and the data access on the one
// memory port; RM needs a third read on that port.
// A two-entry queue separates intake from execution; a request starts only
// when the result register is empty or its result is taken in that cycle.
// Reset clears the CPU registers, the halt flag and the I/O store at once;
// main memory is not cleared and must be loaded before it is read.
// ============================================================================
module bus_cpu_control_unit_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  bcu_pkg::in_t  cmd,
    output logic          res_valid,
    input  logic          res_ready,
    output bcu_pkg::out_t res
);
    import bcu_pkg::*;

    logic q_valid;
    logic q_pop;
    req_t q_head;

    bcu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_head    (q_head)
    );

    bcu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_head    (q_head),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

endmodule
